// ===== rtl/core/fbrq_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrq_pkg
// Shared types and codes for the frame buffer rotation queues.
// ----------------------------------------------------------------------------
package fbrq_pkg;

    localparam int CMD_W    = 2;
    localparam int BUF_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [BUF_W-1:0]    buf_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam cmd_t CMD_CAPTURE_DONE = 2'd0;
    localparam cmd_t CMD_GET_FRAME    = 2'd1;
    localparam cmd_t CMD_RETURN_FRAME = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // ring control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
    } ring_ctrl_t;

    // ring status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

endpackage

// ===== rtl/core/fbrq_req_if.sv =====
// ----------------------------------------------------------------------------
// fbrq_req_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface fbrq_req_if;
    logic               valid;
    logic               ready;
    fbrq_pkg::cmd_t     cmd;
    fbrq_pkg::buf_t     buffer_id;

    modport source (output valid, output cmd, output buffer_id, input ready);
    modport sink   (input valid, input cmd, input buffer_id, output ready);
endinterface

// ===== rtl/core/fbrq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fbrq_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface fbrq_rsp_if;
    logic                valid;
    logic                ready;
    fbrq_pkg::status_t   status;
    fbrq_pkg::buf_t      out_buffer;
    fbrq_pkg::count_t    frame_count;

    modport source (output valid, output status, output out_buffer, output frame_count,
                    input ready);
    modport sink   (input valid, input status, input out_buffer, input frame_count,
                    output ready);
endinterface

// ===== rtl/core/fbrq_ring.sv =====
// ----------------------------------------------------------------------------
// fbrq_ring
// Ring queue of buffer indices in a synchronous memory, head/tail pointers,
// registered read of the head entry. Holds at most DEPTH-1 entries.
// ----------------------------------------------------------------------------
module fbrq_ring #(
    parameter int DEPTH      = 8,
    parameter int INIT_COUNT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fbrq_pkg::ring_ctrl_t ctrl,
    input  fbrq_pkg::buf_t       wr_data,
    output fbrq_pkg::buf_t       rd_data,
    output fbrq_pkg::ring_stat_t stat
);
    import fbrq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] tail_inc;
    logic [PW-1:0] head_inc;

    buf_t mem [DEPTH];
    buf_t mem_rd_reg;

    assign head_inc = (head_reg == LAST) ? '0 : head_reg + PW'(1);
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + PW'(1);

    assign stat.empty = (head_reg == tail_reg);
    assign stat.full  = (tail_inc == head_reg);

    always_comb
    begin
        head_next = ctrl.pop  ? head_inc : head_reg;
        tail_next = ctrl.push ? tail_inc : tail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= PW'(INIT_COUNT);
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            mem_rd_reg <= mem[head_reg];
        end
    end

    generate
        if (INIT_COUNT > 0)
        begin : g_init
            // entries never written read as their preloaded index
            logic [DEPTH-1:0] vld_reg;
            logic             rd_vld_reg;
            buf_t             init_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= '0;
                end
                else if (ctrl.push)
                begin
                    vld_reg[tail_reg] <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctrl.rd_en)
                begin
                    rd_vld_reg <= vld_reg[head_reg];
                    init_reg   <= ({1'b0, head_reg} < (PW+1)'(INIT_COUNT))
                                  ? BUF_W'(head_reg) + BUF_W'(1) : '0;
                end
            end

            assign rd_data = rd_vld_reg ? mem_rd_reg : init_reg;
        end
        else
        begin : g_plain
            assign rd_data = mem_rd_reg;
        end
    endgenerate

endmodule

// ===== rtl/core/frame_buffer_rotation_queues_unit.sv =====
// ----------------------------------------------------------------------------
// frame_buffer_rotation_queues_unit
// Passes buffer indices between a free ring and a filled ring.
// ----------------------------------------------------------------------------
// Each command word passes through S_IDLE and S_EXEC: the accepting edge
// reads the head entries of both rings from their memories, and S_EXEC acts
// on the read data, writes back and loads the result register. A new word is
// taken only once the previous one has been executed; a stalled result holds
// execution. After reset the capture target is buffer 0, the free ring
// holds 1..K with K = min(NUM_BUFFERS-1, FREE_DEPTH-1), the filled ring is
// empty and the frame count is zero; no clearing pass is needed.
module frame_buffer_rotation_queues_unit #(
    parameter int NUM_BUFFERS = 4,
    parameter int FREE_DEPTH  = 8,
    parameter int DONE_DEPTH  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    fbrq_req_if.sink         req,
    fbrq_rsp_if.source       rsp
);
    import fbrq_pkg::*;

    localparam int FREE_INIT = (NUM_BUFFERS - 1 < FREE_DEPTH - 1)
                               ? NUM_BUFFERS - 1 : FREE_DEPTH - 1;

    state_t     state_reg, state_next;

    cmd_t       cmd_reg;
    buf_t       id_reg;
    buf_t       target_reg, target_next;
    count_t     frames_reg, frames_next;

    logic       out_vld_reg, out_vld_next;
    status_t    status_reg, status_next;
    buf_t       obuf_reg, obuf_next;
    count_t     fcount_reg;

    logic       accept;
    logic       fire;

    ring_ctrl_t free_ctrl, done_ctrl;
    ring_stat_t free_stat, done_stat;
    buf_t       free_wdata, done_wdata;
    buf_t       free_rdata, done_rdata;

    fbrq_ring #(
        .DEPTH      (FREE_DEPTH),
        .INIT_COUNT (FREE_INIT)
    ) u_free (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (free_ctrl),
        .wr_data (free_wdata),
        .rd_data (free_rdata),
        .stat    (free_stat)
    );

    fbrq_ring #(
        .DEPTH      (DONE_DEPTH),
        .INIT_COUNT (0)
    ) u_done (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (done_ctrl),
        .wr_data (done_wdata),
        .rd_data (done_rdata),
        .stat    (done_stat)
    );

    assign accept = req.valid && req.ready;
    assign fire   = (state_reg == S_EXEC) && (!out_vld_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req.ready       = (state_reg == S_IDLE);
        free_ctrl       = '0;
        done_ctrl       = '0;
        free_ctrl.rd_en = accept;
        done_ctrl.rd_en = accept;
        free_wdata      = id_reg;
        done_wdata      = target_reg;
        target_next     = target_reg;
        frames_next     = frames_reg;
        status_next     = ST_OK;
        obuf_next       = '0;

        case (cmd_reg)
            CMD_CAPTURE_DONE:
            begin
                if (!free_stat.empty)
                begin
                    free_ctrl.pop = fire;
                    target_next   = free_rdata;
                    if (!done_stat.full)
                    begin
                        done_ctrl.push = fire;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
                frames_next = frames_reg + COUNT_W'(1);
                obuf_next   = target_next;
            end
            CMD_GET_FRAME:
            begin
                if (!done_stat.empty)
                begin
                    done_ctrl.pop = fire;
                    obuf_next     = done_rdata;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            CMD_RETURN_FRAME:
            begin
                if (!free_stat.full)
                begin
                    free_ctrl.push = fire;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        if (fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            target_reg  <= '0;
            frames_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                target_reg <= target_next;
                frames_reg <= frames_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            id_reg  <= req.buffer_id;
        end
        if (fire)
        begin
            status_reg <= status_next;
            obuf_reg   <= obuf_next;
            fcount_reg <= frames_next;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_buffer  = obuf_reg;
    assign rsp.frame_count = fcount_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_buffer_rotation_queues_unit. Command words
// come from a queue that is filled with a directed opening and then with
// random traffic in biased phases. Each accepted word runs through an
// in-bench model of the free and filled rings. The result word that the
// model expects is compared field by field with what the block returns.
// Both channels idle at random, and the result side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb;
    import fbrq_pkg::*;

    localparam int NUM_BUFFERS = 4;
    localparam int FREE_DEPTH  = 8;
    localparam int DONE_DEPTH  = 8;
    localparam int RANDOM_WORDS = 500;

    // selector value with no operation behind it
    localparam cmd_t CMD_UNUSED = 2'd3;

    typedef struct {
        cmd_t cmd;
        buf_t buffer_id;
    } cmd_word_t;

    typedef struct {
        status_t status;
        buf_t    out_buffer;
        count_t  frame_count;
    } result_word_t;

    logic clk;
    logic rst_n;

    fbrq_req_if req();
    fbrq_rsp_if rsp();

    frame_buffer_rotation_queues_unit #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .FREE_DEPTH  (FREE_DEPTH),
        .DONE_DEPTH  (DONE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ring model state
    buf_t   free_ring [FREE_DEPTH];
    buf_t   done_ring [DONE_DEPTH];
    int     free_head, free_tail;
    int     done_head, done_tail;
    buf_t   capture_buf;
    count_t frames_seen;

    cmd_word_t    pending_words[$];
    result_word_t expected_results[$];

    int  error_count;
    int  words_in;
    int  results_out;
    int  cmd_tally [4];
    int  empty_seen, full_seen;

    bit  word_taken;
    int  burst_left, gap_left;
    bit  hold_off;
    int  stall_mode, stall_left;

    always #2 clk = ~clk;

    function automatic int ring_fill(int head, int tail, int depth);
        return (tail + depth - head) % depth;
    endfunction

    task automatic report_mismatch(string what, count_t want, count_t got);
        error_count++;
        if (error_count <= 30)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic rings_to_reset();
        int k;
        k = NUM_BUFFERS - 1;
        if (k > FREE_DEPTH - 1)
            k = FREE_DEPTH - 1;
        for (int i = 0; i < FREE_DEPTH; i++)
            free_ring[i] = (i < k) ? buf_t'(i + 1) : '0;
        free_head   = 0;
        free_tail   = k;
        done_head   = 0;
        done_tail   = 0;
        capture_buf = '0;
        frames_seen = '0;
    endtask

    task automatic predict_result(input cmd_word_t w, output result_word_t r);
        buf_t taken;
        r.status     = ST_OK;
        r.out_buffer = '0;
        case (w.cmd)
            CMD_CAPTURE_DONE:
            begin
                if (free_head != free_tail)
                begin
                    taken     = free_ring[free_head];
                    free_head = (free_head + 1) % FREE_DEPTH;
                    // old target is lost when the filled ring has no room
                    if (ring_fill(done_head, done_tail, DONE_DEPTH) >= DONE_DEPTH - 1)
                        r.status = ST_FULL;
                    else
                    begin
                        done_ring[done_tail] = capture_buf;
                        done_tail = (done_tail + 1) % DONE_DEPTH;
                    end
                    capture_buf = taken;
                end
                else
                    r.status = ST_EMPTY;
                frames_seen  = frames_seen + 1;
                r.out_buffer = capture_buf;
            end
            CMD_GET_FRAME:
            begin
                if (done_head == done_tail)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_buffer = done_ring[done_head];
                    done_head = (done_head + 1) % DONE_DEPTH;
                end
            end
            CMD_RETURN_FRAME:
            begin
                if (ring_fill(free_head, free_tail, FREE_DEPTH) >= FREE_DEPTH - 1)
                    r.status = ST_FULL;
                else
                begin
                    free_ring[free_tail] = w.buffer_id;
                    free_tail = (free_tail + 1) % FREE_DEPTH;
                end
            end
            default:
                ;
        endcase
        r.frame_count = frames_seen;
    endtask

    // command driver: bursts of words with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            req.valid <= 1'b0;
        else if (req.valid && !word_taken)
            ;  // word still on offer, hold it
        else
        begin
            word_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                req.valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                req.valid     <= 1'b1;
                req.cmd       <= pending_words[0].cmd;
                req.buffer_id <= pending_words[0].buffer_id;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // result side: stall pattern changes every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 60);
        end
        else
            stall_left--;
        if (hold_off)
            rsp.ready <= 1'b0;
        else
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                2: rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= stall_left[0];
            endcase
    end

    // monitor: takes accepted command words into the model, checks results
    always @(posedge clk)
    begin
        result_word_t want;
        cmd_word_t    w;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_out++;
                if (rsp.status == ST_EMPTY)
                    empty_seen++;
                if (rsp.status == ST_FULL)
                    full_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result word (frame_count)", '0,
                                    rsp.frame_count);
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", count_t'(want.status),
                                        count_t'(rsp.status));
                    if (rsp.out_buffer !== want.out_buffer)
                        report_mismatch("out_buffer", count_t'(want.out_buffer),
                                        count_t'(rsp.out_buffer));
                    if (rsp.frame_count !== want.frame_count)
                        report_mismatch("frame_count", want.frame_count, rsp.frame_count);
                end
            end
            if (req.valid && req.ready)
            begin
                word_taken = 1'b1;
                words_in++;
                w = pending_words.pop_front();
                cmd_tally[w.cmd]++;
                predict_result(w, want);
                expected_results.push_back(want);
            end
        end
    end

    // long result hold-off while command words are still on offer
    initial
    begin
        hold_off = 1'b0;
        wait (words_in >= 150);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        cmd_word_t w;
        int cap_w, get_w, roll;

        clk           = 1'b0;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.cmd       = CMD_CAPTURE_DONE;
        req.buffer_id = '0;
        rsp.ready     = 1'b0;
        word_taken    = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        stall_mode    = 0;
        stall_left    = 0;
        error_count   = 0;
        words_in      = 0;
        results_out   = 0;
        empty_seen    = 0;
        full_seen     = 0;
        cmd_tally     = '{default: 0};
        rings_to_reset();

        // opening: get on empty, unused selector, fill and overfill the free
        // ring, run the filled ring full, drop a target, drain a little
        pending_words.push_back('{CMD_GET_FRAME, 4'd0});
        pending_words.push_back('{CMD_UNUSED, 4'd10});
        pending_words.push_back('{CMD_RETURN_FRAME, 4'd15});
        pending_words.push_back('{CMD_RETURN_FRAME, 4'd0});
        pending_words.push_back('{CMD_RETURN_FRAME, 4'd5});
        pending_words.push_back('{CMD_RETURN_FRAME, 4'd10});
        pending_words.push_back('{CMD_RETURN_FRAME, 4'd9});
        repeat (7) pending_words.push_back('{CMD_CAPTURE_DONE, 4'd15});
        pending_words.push_back('{CMD_CAPTURE_DONE, 4'd0});
        pending_words.push_back('{CMD_RETURN_FRAME, 4'd3});
        pending_words.push_back('{CMD_CAPTURE_DONE, 4'd0});
        pending_words.push_back('{CMD_GET_FRAME, 4'd15});
        pending_words.push_back('{CMD_GET_FRAME, 4'd0});
        pending_words.push_back('{CMD_CAPTURE_DONE, 4'd0});

        // random traffic in phases that lean towards one operation
        cap_w = 32;
        get_w = 32;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 50 == 0)
                case ($urandom_range(0, 3))
                    0: begin cap_w = 32; get_w = 32; end
                    1: begin cap_w = 70; get_w = 13; end
                    2: begin cap_w = 20; get_w = 60; end
                    default: begin cap_w = 20; get_w = 16; end
                endcase
            roll = $urandom_range(0, 99);
            if (roll < 4)
                w.cmd = CMD_UNUSED;
            else if (roll < 4 + cap_w)
                w.cmd = CMD_CAPTURE_DONE;
            else if (roll < 4 + cap_w + get_w)
                w.cmd = CMD_GET_FRAME;
            else
                w.cmd = CMD_RETURN_FRAME;
            if (w.cmd == CMD_RETURN_FRAME && $urandom_range(0, 4) != 0)
                w.buffer_id = buf_t'($urandom_range(0, NUM_BUFFERS - 1));
            else
                w.buffer_id = buf_t'($urandom_range(0, 15));
            pending_words.push_back(w);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d command words: %0d captures, %0d gets, %0d returns, %0d unused.",
                 words_in, cmd_tally[CMD_CAPTURE_DONE], cmd_tally[CMD_GET_FRAME],
                 cmd_tally[CMD_RETURN_FRAME], cmd_tally[CMD_UNUSED]);
        $display("Checked %0d results, %0d with a ring empty, %0d with a ring full.",
                 results_out, empty_seen, full_seen);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== frame_buffer_rotation_queues_unit.f =====
rtl/core/fbrq_pkg.sv
rtl/core/fbrq_req_if.sv
rtl/core/fbrq_rsp_if.sv
rtl/core/fbrq_ring.sv
rtl/core/frame_buffer_rotation_queues_unit.sv
tb/tb.sv
